@@ rtl/assert_macros.svh @@
// Assertion macros used by the mixer controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LSVM_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define LSVM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LSVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LSVM_ASSERT(lbl, clk, rst, expr, msg)
`define LSVM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define LSVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/lsvm_pkg.sv @@
// Shared constants, payload types and controller types for the voice mixer.
package lsvm_pkg;
   localparam int VOICES           = 4;
   localparam int SAMPLE_ADDR_BITS = 17;
   localparam int MEM_DEPTH        = 1 << SAMPLE_ADDR_BITS;
   localparam int VIDX_BITS        = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ACC_BITS         = 16 + VIDX_BITS + 1;
   localparam logic [17:0] NO_LOOP_LIMIT = 18'd2;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_SETUP = 2'd1,
      ACT_FRAME = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         channel;
      logic [16:0]        mem_address;
      logic signed [7:0]  sample_byte;
      logic [16:0]        sample_base;
      logic [17:0]        sample_length;
      logic [16:0]        loop_begin;
      logic [17:0]        loop_span;
      logic [19:0]        pitch_step;
      logic [6:0]         volume;
      logic               restart;
      logic               enabled;
   } req_payload_type;

   typedef struct packed {
      logic signed [7:0] mix_sample;
   } rsp_payload_type;

   typedef struct packed {
      logic                 mem_write;
      logic                 voice_write;
      logic                 frame_start;
      logic                 eval;
      logic                 emit;
      logic [VIDX_BITS-1:0] vidx;
   } cmd_type;
endpackage

@@ rtl/lsvm_channels.sv @@
// Request and response channel interfaces.
interface lsvm_req_if;
   import lsvm_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lsvm_rsp_if;
   import lsvm_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/lsvm_ram.sv @@
// Generic single-port RAM with registered read data.
module lsvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/lsvm_ctrl.sv @@
// Controller state machine: request decode, voice sequencing and response slot.
`include "assert_macros.svh"
module lsvm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_action,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsvm_pkg::cmd_type cmd
);
   import lsvm_pkg::*;

   localparam logic [VIDX_BITS-1:0] LAST_VOICE = VIDX_BITS'(VOICES - 1);

   state_type            state_ff, state_in;
   logic [VIDX_BITS-1:0] vidx_ff, vidx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vidx_ff      <= vidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      vidx_in         = vidx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.vidx        = vidx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            vidx_in   = '0;
            if (req_valid) begin
               case (req_action)
                  ACT_LOAD: cmd.mem_write = 1'b1;
                  ACT_SETUP: cmd.voice_write = 1'b1;
                  ACT_FRAME: begin
                     cmd.frame_start = 1'b1;
                     state_in        = ST_EVAL;
                  end
                  default: ;
               endcase
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (vidx_ff == LAST_VOICE) begin
               state_in = ST_DRAIN;
               vidx_in  = '0;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `LSVM_ASSERT_IMPL(a_emit_slot, clock, reset, cmd.emit, !(rsp_valid_ff && !rsp_ready), "emit over held response")
   `LSVM_ASSERT_IMPL(a_idle_vidx, clock, reset, state_ff == ST_IDLE, vidx_ff == '0, "voice index not cleared")
   `LSVM_ASSERT_NEXT(a_last_drain, clock, reset, state_ff == ST_EVAL && vidx_ff == LAST_VOICE, state_ff == ST_DRAIN, "no drain after last voice")
   `LSVM_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff, "emit without response valid")
endmodule

@@ rtl/lsvm_datapath.sv @@
// Datapath: voice registers, sample memory, voice evaluation and mix accumulator.
module lsvm_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  lsvm_pkg::req_payload_type req,
   input  lsvm_pkg::cmd_type        cmd,
   output logic signed [7:0]        mix_sample
);
   import lsvm_pkg::*;

   logic [32:0] pos_ff     [VOICES];
   logic        fin_ff     [VOICES];
   logic        en_ff      [VOICES];
   logic [16:0] base_ff    [VOICES];
   logic [17:0] len_ff     [VOICES];
   logic [16:0] lbegin_ff  [VOICES];
   logic [17:0] lspan_ff   [VOICES];
   logic [19:0] step_ff    [VOICES];
   logic [6:0]  gain_v_ff  [VOICES];

   logic [6:0]                gain_ff;
   logic                      mac_pending_ff, mac_pending_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic signed [7:0]         mix_ff;

   logic [32:0]               pos_cur, pos_a, pos_next;
   logic [16:0]               int_part;
   logic [18:0]               loop_end;
   logic                      looping, wrap, fin_a, play;
   logic [17:0]               addr_sum;
   logic [SAMPLE_ADDR_BITS-1:0] ram_addr;
   logic [7:0]                ram_rdata;
   logic signed [15:0]        prod;
   logic                      round_up;

   assign pos_cur  = pos_ff[cmd.vidx];
   assign int_part = pos_cur[32:16];
   assign looping  = lspan_ff[cmd.vidx] > NO_LOOP_LIMIT;
   assign loop_end = {2'b00, lbegin_ff[cmd.vidx]} + {1'b0, lspan_ff[cmd.vidx]};
   assign wrap     = looping && ({2'b00, int_part} >= loop_end);
   assign pos_a    = wrap ? {lbegin_ff[cmd.vidx], 16'h0000} : pos_cur;
   assign fin_a    = fin_ff[cmd.vidx] ||
                     (!looping && ({1'b0, int_part} >= len_ff[cmd.vidx]));
   assign play     = en_ff[cmd.vidx] && (looping || !fin_a);
   assign pos_next = pos_a + {13'd0, step_ff[cmd.vidx]};
   assign addr_sum = {1'b0, base_ff[cmd.vidx]} + {1'b0, pos_a[32:16]};
   assign ram_addr = cmd.mem_write ? SAMPLE_ADDR_BITS'(req.mem_address)
                                   : SAMPLE_ADDR_BITS'(addr_sum);

   lsvm_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_sample_ram (
      .clock (clock),
      .we    (cmd.mem_write),
      .addr  (ram_addr),
      .wdata (req.sample_byte),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            pos_ff[v] <= '0;
            fin_ff[v] <= 1'b0;
            en_ff[v]  <= 1'b0;
         end
      end else begin
         for (int v = 0; v < VOICES; v++) begin
            if (cmd.voice_write && 32'(req.channel) == v) begin
               en_ff[v] <= req.enabled;
               if (req.restart) begin
                  pos_ff[v] <= '0;
                  fin_ff[v] <= 1'b0;
               end
            end
         end
         if (cmd.eval && en_ff[cmd.vidx]) begin
            pos_ff[cmd.vidx] <= play ? pos_next : pos_a;
            fin_ff[cmd.vidx] <= fin_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int v = 0; v < VOICES; v++) begin
         if (cmd.voice_write && 32'(req.channel) == v) begin
            base_ff[v]   <= req.sample_base;
            len_ff[v]    <= req.sample_length;
            lbegin_ff[v] <= req.loop_begin;
            lspan_ff[v]  <= req.loop_span;
            step_ff[v]   <= req.pitch_step;
            gain_v_ff[v] <= req.volume;
         end
      end
   end

   assign prod           = $signed(ram_rdata) * $signed({1'b0, gain_ff});
   assign mac_pending_in = cmd.eval && play;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.frame_start) begin
         acc_in = '0;
      end else if (mac_pending_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod);
      end
   end

   assign round_up = acc_ff[ACC_BITS-1] && (acc_ff[7:0] != 8'h00);

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_pending_ff <= 1'b0;
      end else begin
         mac_pending_ff <= mac_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_v_ff[cmd.vidx];
      acc_ff  <= acc_in;
      if (cmd.emit) begin
         mix_ff <= acc_ff[15:8] + {7'd0, round_up};
      end
   end

   assign mix_sample = mix_ff;
endmodule

@@ rtl/looping_sample_voice_mixer_core.sv @@
// Top level of the looping four-voice sample mixer.
// Usage: every request on req_bus carries an action. A load request writes
// sample_byte into sample memory at mem_address; a set-up request stores the
// voice parameters for the given channel and, with restart, clears its
// position and finished mark; a frame request mixes one output frame that
// appears as mix_sample on rsp_bus. Action code 3 is taken and ignored.
// Load and set-up requests give no response.
// A frame request visits one voice per cycle through the single sample
// memory port, then passes a drain state and an emit state that loads the
// response register; the next request is taken back in the idle state.
// The response sits in an output register, so loads and set-ups are still
// taken while rsp_bus is stalled; a following frame waits at its end until
// the held response has been taken.
// Synchronous reset disables all voices and clears positions and finished
// marks; the sample memory content is undefined until written.
module looping_sample_voice_mixer_core (
   input logic        clock,
   input logic        reset,
   lsvm_req_if.sink   req_bus,
   lsvm_rsp_if.source rsp_bus
);
   import lsvm_pkg::*;

   cmd_type cmd;

   lsvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.payload.action),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .cmd        (cmd)
   );

   lsvm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus.payload),
      .cmd        (cmd),
      .mix_sample (rsp_bus.payload.mix_sample)
   );
endmodule
